FILE: src/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
// Used by bdlp_poll_unit and button_debounce_long_press_core; no dependencies.
package bdlp_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_DOWN  = 2'd1;
    localparam logic [1:0] EV_SHORT = 2'd2;
    localparam logic [1:0] EV_LONG  = 2'd3;

    localparam logic CFG_IDX_DEBOUNCE   = 1'b0;
    localparam logic CFG_IDX_LONG_PRESS = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd25;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd700;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic              step;
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

endpackage

FILE: src/bdlp_poll_unit.sv
// Debounce and long-press state with the per-poll decision logic.
// Depends on bdlp_pkg (poll_t, cfg_t, event codes).
module bdlp_poll_unit
    import bdlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  poll_t      poll,
    input  cfg_t       cfg,
    output logic [1:0] event_code
);

    logic              stable_reg;
    logic              stable_next;
    logic              last_raw_reg;
    logic              last_raw_next;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] press_time_reg;
    logic [TIME_W-1:0] press_time_next;
    logic              long_done_reg;
    logic              long_done_next;

    logic              raw_changed;
    logic [TIME_W-1:0] held_ms;
    logic [TIME_W-1:0] pressed_ms;
    logic              settle;
    logic              long_hit;

    assign raw_changed = poll.raw_level != last_raw_reg;
    // A fresh edge restarts the debounce timer at this very poll.
    assign held_ms     = raw_changed ? '0 : (poll.now_ms - change_time_reg);
    assign pressed_ms  = poll.now_ms - press_time_reg;
    assign settle      = (poll.raw_level != stable_reg)
                         && (held_ms >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});
    assign long_hit    = !stable_reg && !long_done_reg
                         && (pressed_ms >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time});

    always_comb
    begin
        last_raw_next    = last_raw_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        press_time_next  = press_time_reg;
        long_done_next   = long_done_reg;
        event_code       = EV_NONE;
        if (raw_changed)
        begin
            last_raw_next    = poll.raw_level;
            change_time_next = poll.now_ms;
        end
        if (settle)
        begin
            stable_next = poll.raw_level;
            if (!poll.raw_level)
            begin
                press_time_next = poll.now_ms;
                long_done_next  = 1'b0;
                event_code      = EV_DOWN;
            end
            else
            begin
                event_code = long_done_reg ? EV_NONE : EV_SHORT;
            end
        end
        else if (long_hit)
        begin
            long_done_next = 1'b1;
            event_code     = EV_LONG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b1;
            last_raw_reg    <= 1'b1;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            long_done_reg   <= 1'b0;
        end
        else if (poll.step)
        begin
            stable_reg      <= stable_next;
            last_raw_reg    <= last_raw_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            long_done_reg   <= long_done_next;
        end
    end

    a_down_sets_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (poll.step && event_code == EV_DOWN) |=> (!stable_reg && !long_done_reg))
        else $error("DOWN did not leave the button pressed with long flag clear");

    a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (poll.step && event_code == EV_LONG) |=> long_done_reg)
        else $error("LONG did not set the long-press flag");

    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        long_done_reg |-> (event_code != EV_LONG))
        else $error("LONG offered twice for one press");

    a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (event_code == EV_SHORT) |-> (!stable_reg && poll.raw_level && !long_done_reg))
        else $error("SHORT without a release of a short press");

endmodule

FILE: src/button_debounce_long_press_core.sv
// Top level of the button debouncer with long-press detection.
// Depends on bdlp_pkg and bdlp_poll_unit.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per poll, carrying the raw
//   active-low pin level raw_level and the millisecond timestamp now_ms.
//   Output channel (out_valid / out_stall): exactly one word per poll,
//   event_res = 0 none, 1 press down, 2 short press, 3 long press.
//   Configuration: cfg_write with cfg_index 0 sets debounce_time, index 1
//   sets long_press_time (low 16 bits of cfg_data). Write only while idle.
// Pipeline and throughput:
//   A poll is registered in the input register on accept, evaluated against
//   the debounce state when it advances and its event is registered in the
//   result register, which drives out_valid.
//   The block takes one poll every cycle while out_stall is low; the input
//   register and result register advance together.
// Stall:
//   While out_stall holds a waiting result, the input register still holds
//   one more poll, then in_stall rises until the result is taken.
// Reset:
//   Button state returns to released and idle (timers at zero, no long press
//   pending), the registers return to 25 ms and 700 ms, both channels empty.
module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              raw_level,
    input  logic [TIME_W-1:0] now_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_res,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              raw_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg;
    logic [1:0]        event_reg;

    logic              advance;
    logic              take_in;
    logic [1:0]        event_code;
    poll_t             poll;

    // Move the held poll into the result register when that slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign poll.step      = advance;
    assign poll.raw_level = raw_reg;
    assign poll.now_ms    = now_reg;

    bdlp_poll_unit u_poll
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll       (poll),
        .cfg        (cfg_reg),
        .event_code (event_code)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEBOUNCE_RESET;
            cfg_reg.long_press_time <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_DEBOUNCE:   cfg_reg.debounce_time   <= cfg_data;
                CFG_IDX_LONG_PRESS: cfg_reg.long_press_time <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input register: hold the poll until it advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take_in)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            raw_reg <= raw_level;
            now_reg <= now_ms;
        end
    end

    // Result register: hold the event while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            event_reg <= event_code;
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced poll did not reach the result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("stalled result overwritten");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg)
        else $error("input register dropped a stalled poll");

endmodule

FILE: bench/bdlp_event_checker.sv
// Event scoreboard for button_debounce_long_press_core.
// Predicts one event per accepted poll and compares it with the result channel.
// Depends on bdlp_pkg; instantiated beside the block by the testbench top.
module bdlp_event_checker
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              raw_level,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        event_res,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                mismatch_count,
    output int                events_waiting,
    output int                events_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]  settle_limit;
    logic [CFG_W-1:0]  long_press_ms;
    logic              level_debounced;
    logic              raw_seen;
    logic [TIME_W-1:0] raw_since;
    logic [TIME_W-1:0] pressed_at;
    logic              long_fired;
    logic [1:0]        expected_events [$];

    // Advance the button state by one poll and return the event it raises.
    function automatic logic [1:0] next_button_event(input logic raw,
                                                     input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_press;
        if (raw != raw_seen) begin
            raw_seen  = raw;
            raw_since = now;
        end
        since_change = now - raw_since;
        if (raw != level_debounced && since_change >= TIME_W'(settle_limit)) begin
            level_debounced = raw;
            if (!raw) begin
                pressed_at = now;
                long_fired = 1'b0;
                return EV_DOWN;
            end
            return long_fired ? EV_NONE : EV_SHORT;
        end
        since_press = now - pressed_at;
        if (!level_debounced && !long_fired && since_press >= TIME_W'(long_press_ms)) begin
            long_fired = 1'b1;
            return EV_LONG;
        end
        return EV_NONE;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        logic [1:0] want;
        if (!rst_n) begin
            settle_limit    = DEBOUNCE_RESET;
            long_press_ms   = LONG_PRESS_RESET;
            level_debounced = 1'b1;
            raw_seen        = 1'b1;
            raw_since       = '0;
            pressed_at      = '0;
            long_fired      = 1'b0;
            expected_events.delete();
            mismatch_count  = 0;
            events_waiting  = 0;
            events_checked  = 0;
        end
        else begin
            // Retire the oldest prediction before adding this edge's poll.
            if (out_valid && !out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("event_res: expected no word, actual %0d", event_res);
                    mismatch_count++;
                end
                else begin
                    want = expected_events.pop_front();
                    events_checked++;
                    if (event_res !== want) begin
                        $error("event_res: expected %0d, actual %0d", want, event_res);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_events.push_back(next_button_event(raw_level, now_ms));
            if (cfg_write) begin
                if (cfg_index == CFG_IDX_DEBOUNCE)
                    settle_limit = cfg_data;
                else
                    long_press_ms = cfg_data;
            end
            events_waiting = expected_events.size();
        end
    end

endmodule

FILE: bench/button_debounce_long_press_core_tb.sv
// Testbench top for button_debounce_long_press_core.
// Drives polls and register writes, stalls the result side, reports the verdict.
// Depends on bdlp_pkg, the block itself and bdlp_event_checker.
module button_debounce_long_press_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdlp_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              raw_level = 1'b1;
    logic [TIME_W-1:0] now_ms    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        event_res;
    logic              cfg_write = 1'b0;
    logic              cfg_index = CFG_IDX_DEBOUNCE;
    logic [CFG_W-1:0]  cfg_data  = '0;

    int mismatch_count;
    int events_waiting;
    int events_checked;

    // Sender bookkeeping: words left in the current burst, words sent, settings run.
    int                burst_left   = 0;
    int                polls_sent   = 0;
    int                settings_run = 0;
    logic [TIME_W-1:0] clock_ms     = '0;
    logic [CFG_W-1:0]  cur_debounce = DEBOUNCE_RESET;
    logic [CFG_W-1:0]  cur_long     = LONG_PRESS_RESET;

    // Receiver stall pattern: a mode held for a random stretch of cycles.
    int          stall_mode = 0;
    int          stall_left = 0;
    logic [7:0]  stall_tick = '0;

    button_debounce_long_press_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_level (raw_level),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bdlp_event_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_level      (raw_level),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .events_waiting (events_waiting),
        .events_checked (events_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hold out_stall on one of four patterns: never, light random, periodic,
    // heavy random. Each pattern lasts a random stretch so gaps hit every phase.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= stall_tick[2];
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Present one poll word and hold it until the block takes it. Bursts of
    // random length are separated by random idle gaps; a zero gap keeps
    // in_valid high straight through.
    task automatic send_poll(input logic raw, input logic [TIME_W-1:0] stamp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid  <= 1'b1;
        raw_level <= raw;
        now_ms    <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        polls_sent++;
    endtask

    // Drop in_valid and wait until every predicted event has come back, then
    // let the pipeline drain.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (events_waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; cfg_write stays high between.
    task automatic write_settings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_DEBOUNCE;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= CFG_IDX_LONG_PRESS;
        cfg_data  <= lng;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_debounce = deb;
        cur_long     = lng;
        settings_run++;
    endtask

    // Contact chatter: a few alternating samples, each inside the debounce window.
    task automatic chatter(input logic settle);
        int count;
        count = $urandom_range(0, 3);
        for (int i = 0; i < count; i++)
        begin
            clock_ms = clock_ms + $urandom_range(0, cur_debounce / 2);
            send_poll((i % 2 == 0) ? settle : !settle, clock_ms);
        end
    endtask

    // Hold one level for span ms, sampled at a handful of polls.
    task automatic dwell(input logic level, input logic [TIME_W-1:0] span);
        int          steps;
        logic [TIME_W-1:0] stride;
        steps  = $urandom_range(1, 6);
        stride = span / steps;
        send_poll(level, clock_ms);
        for (int i = 0; i < steps; i++)
        begin
            clock_ms = clock_ms + stride;
            if (i == steps - 1)
                clock_ms = clock_ms + span % steps;
            if ($urandom_range(0, 3) == 0)
                clock_ms = clock_ms + $urandom_range(0, 2);
            send_poll(level, clock_ms);
        end
    endtask

    // One press and release with bounce on both edges. The hold is chosen
    // to fall short of debounce, land before the long threshold, sit right
    // on it, or run well past it.
    task automatic press_gesture();
        logic [TIME_W-1:0] hold;
        case ($urandom_range(0, 3))
            0:       hold = $urandom_range(0, cur_debounce);
            1:       hold = cur_debounce + $urandom_range(0, cur_long);
            2:       hold = cur_debounce + cur_long;
            default: hold = cur_debounce + cur_long + $urandom_range(1, cur_long + 50);
        endcase
        chatter(1'b0);
        dwell(1'b0, hold);
        chatter(1'b1);
        dwell(1'b1, cur_debounce + $urandom_range(0, cur_debounce + 10));
    endtask

    initial
    begin : timeout
        #1_000_000;
        $display("button_debounce_long_press_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lng;
        int               phase_start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings (25 ms debounce, 700 ms long).
        // Press accepted exactly at the debounce limit, long press exactly at
        // its limit, then release after a long press gives no event.
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'd10);
        send_poll(1'b0, 32'd34);
        send_poll(1'b0, 32'd35);
        send_poll(1'b0, 32'd734);
        send_poll(1'b0, 32'd735);
        send_poll(1'b1, 32'd810);
        send_poll(1'b1, 32'd835);
        // Short press with release inside the long threshold.
        send_poll(1'b0, 32'd900);
        send_poll(1'b0, 32'd930);
        send_poll(1'b1, 32'd950);
        send_poll(1'b1, 32'd980);
        // Timestamp wrap across zero, then a step backwards that looks like
        // a huge interval and fires the long press at once.
        send_poll(1'b0, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'h0000_0005);
        send_poll(1'b0, 32'h0000_000A);
        send_poll(1'b0, 32'h0000_0009);
        // Bounce at the top timestamp, then release after the long press.
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'h0000_0000);
        send_poll(1'b1, 32'h0000_0019);

        // Random part: one block of gestures per register setting.
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       begin deb = 16'd0;     lng = 16'd0;     end
                1:       begin deb = 16'hFFFF;  lng = 16'hFFFF;  end
                2:       begin deb = 16'd0;     lng = 16'hFFFF;  end
                3:       begin deb = 16'hFFFF;  lng = 16'd0;     end
                4:       begin deb = 16'd3;     lng = 16'd20;    end
                8:
                begin
                    deb = CFG_W'($urandom_range(0, 16'hFFFF));
                    lng = CFG_W'($urandom_range(0, 16'hFFFF));
                end
                9:       begin deb = DEBOUNCE_RESET; lng = LONG_PRESS_RESET; end
                default:
                begin
                    deb = CFG_W'($urandom_range(0, 200));
                    lng = CFG_W'($urandom_range(0, 2000));
                end
            endcase
            wait_idle();
            write_settings(deb, lng);

            // Start some phases just below the wrap point.
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
            else
                clock_ms = $urandom;

            phase_start = polls_sent;
            while (polls_sent - phase_start < 100)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // Noise: arbitrary level at an arbitrary timestamp.
                    clock_ms = $urandom;
                    send_poll(1'($urandom_range(0, 1)), clock_ms);
                end
                else
                begin
                    press_gesture();
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Sent %0d polls over %0d register settings (limits at 0 and 65535 included)",
                 polls_sent, settings_run);
        $display("Compared %0d events, %0d mismatching", events_checked, mismatch_count);
        if (mismatch_count == 0 && events_waiting == 0)
            $display("button_debounce_long_press_core: match");
        else
            $display("button_debounce_long_press_core: mismatch");
        $finish;
    end

endmodule

FILE: button_debounce_long_press_core.f
src/bdlp_pkg.sv
src/bdlp_poll_unit.sv
src/button_debounce_long_press_core.sv
bench/bdlp_event_checker.sv
bench/button_debounce_long_press_core_tb.sv
